// ===== sv/dopq_pkg.sv =====
`default_nettype none

package dopq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 1;

    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Register indexes on the configuration port (byte address = 4 * index).
    localparam logic [1:0] REG_ITEM_LIMIT    = 2'd0;
    localparam logic [1:0] REG_STATUS_ENABLE = 2'd1;
    localparam logic [1:0] REG_STATUS_TOPIC  = 2'd2;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_POP     = 1'b1;

    localparam logic [1:0] RC_ENQUEUED = 2'd0;
    localparam logic [1:0] RC_POPPED   = 2'd1;
    localparam logic [1:0] RC_EMPTY    = 2'd2;

    localparam logic [4:0]  ITEM_LIMIT_RESET = 5'd16;
    localparam logic [15:0] CNT_SAT          = 16'hFFFF;

    typedef struct packed {
        logic [15:0] topic;
        logic [15:0] payload;
        logic [1:0]  qos;
        logic        retain;
    } item_t;

    // Bring a head-plus-offset sum back into the ring. The sum is always
    // below twice the capacity, so one compare and subtract is enough.
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] r;
        r = (v >= SUM_W'(CAPACITY)) ? v - SUM_W'(CAPACITY) : v;
        return r[IDX_W-1:0];
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] c);
        return (c != CNT_SAT) ? c + 16'd1 : c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/drop_oldest_publish_queue.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    opcode, topic_id, payload_handle, qos, retain
// m_        out        m_valid / m_ready    result_code, item fields, counts and totals
// apb       in         psel/penable/pready  item limit, status enable, status topic
//
// Each request is decided in the cycle it is accepted; its result is in the output
// register in the next cycle; one request per cycle is sustained while m_ready is high.
// Reset (aresetn low at a clock edge) empties the ring and the status slot, clears
// both totals and restores the registers to their defaults.
// A stalled result holds the output register; s_ready is low only while a result
// waits and m_ready is low.

module drop_oldest_publish_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_opcode,
    input  wire logic [15:0] s_topic_id,
    input  wire logic [15:0] s_payload_handle,
    input  wire logic [1:0]  s_qos,
    input  wire logic        s_retain,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_code,
    output logic [15:0]      m_out_topic_id,
    output logic [15:0]      m_out_payload,
    output logic [1:0]       m_out_qos,
    output logic             m_out_retain,
    output logic             m_out_from_status,
    output logic [4:0]       m_queued_count,
    output logic [15:0]      m_dropped_total,
    output logic [15:0]      m_replaced_total,

    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [dopq_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [dopq_pkg::PDATA_W-1:0]    pwdata,
    output logic      [dopq_pkg::PDATA_W-1:0]    prdata,
    output logic                                 pready
);

    // Configuration registers
    logic [4:0]  item_limit_reg;
    logic        status_en_reg;
    logic [15:0] status_topic_reg;

    // Queue state
    dopq_pkg::item_t                ring_reg [dopq_pkg::CAPACITY];
    logic [dopq_pkg::IDX_W-1:0]     head_reg, head_next;
    logic [dopq_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                           status_valid_reg, status_valid_next;
    dopq_pkg::item_t                status_entry_reg, status_entry_next;
    logic [15:0]                    drop_cnt_reg, drop_cnt_next;
    logic [15:0]                    repl_cnt_reg, repl_cnt_next;

    // Output register
    logic                           m_valid_reg;
    logic [1:0]                     code_reg, code_next;
    dopq_pkg::item_t                got_reg, got_next;
    logic                           from_status_reg, from_status_next;

    logic                           accept;
    logic                           cfg_wr;
    dopq_pkg::item_t                item_in;
    logic                           to_status;
    logic [dopq_pkg::CNT_W-1:0]     limit;
    logic                           ring_full;
    logic [dopq_pkg::IDX_W-1:0]     head_adj;
    logic [dopq_pkg::CNT_W-1:0]     count_adj;
    logic [dopq_pkg::IDX_W-1:0]     wr_idx;
    logic                           ring_we;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    assign item_in = '{topic: s_topic_id, payload: s_payload_handle,
                       qos: s_qos, retain: s_retain};

    assign to_status = status_en_reg && (s_topic_id == status_topic_reg);

    // A zero or oversized limit means the whole ring.
    always_comb begin
        if ((item_limit_reg == 5'd0) || (32'(item_limit_reg) > dopq_pkg::CAPACITY)) begin
            limit = dopq_pkg::CNT_W'(dopq_pkg::CAPACITY);
        end else begin
            limit = dopq_pkg::CNT_W'(item_limit_reg);
        end
    end

    // When the limit was lowered below the fill, only one entry is dropped per
    // enqueue, so the count stays put until pops bring it down.
    assign ring_full = (count_reg >= limit) && (count_reg != '0);
    assign head_adj  = ring_full
                     ? dopq_pkg::wrap_idx(dopq_pkg::SUM_W'(head_reg) + dopq_pkg::SUM_W'(1))
                     : head_reg;
    assign count_adj = ring_full ? count_reg - dopq_pkg::CNT_W'(1) : count_reg;
    assign wr_idx    = dopq_pkg::wrap_idx(dopq_pkg::SUM_W'(head_adj)
                                          + dopq_pkg::SUM_W'(count_adj));

    always_comb begin
        head_next         = head_reg;
        count_next        = count_reg;
        status_valid_next = status_valid_reg;
        status_entry_next = status_entry_reg;
        drop_cnt_next     = drop_cnt_reg;
        repl_cnt_next     = repl_cnt_reg;
        code_next         = dopq_pkg::RC_ENQUEUED;
        got_next          = '0;
        from_status_next  = 1'b0;
        ring_we           = 1'b0;

        if (s_opcode == dopq_pkg::OP_ENQUEUE) begin
            if (to_status) begin
                if (status_valid_reg) begin
                    repl_cnt_next = dopq_pkg::sat_inc(repl_cnt_reg);
                end
                status_entry_next = item_in;
                status_valid_next = 1'b1;
            end else begin
                if (ring_full) begin
                    drop_cnt_next = dopq_pkg::sat_inc(drop_cnt_reg);
                end
                head_next  = head_adj;
                count_next = count_adj + dopq_pkg::CNT_W'(1);
                ring_we    = 1'b1;
            end
        end else if (count_reg != '0) begin
            code_next  = dopq_pkg::RC_POPPED;
            got_next   = ring_reg[head_reg];
            head_next  = dopq_pkg::wrap_idx(dopq_pkg::SUM_W'(head_reg) + dopq_pkg::SUM_W'(1));
            count_next = count_reg - dopq_pkg::CNT_W'(1);
        end else if (status_valid_reg) begin
            code_next         = dopq_pkg::RC_POPPED;
            got_next          = status_entry_reg;
            from_status_next  = 1'b1;
            status_entry_next = '0;
            status_valid_next = 1'b0;
        end else begin
            code_next = dopq_pkg::RC_EMPTY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg         <= '0;
            count_reg        <= '0;
            status_valid_reg <= 1'b0;
            status_entry_reg <= '0;
            drop_cnt_reg     <= '0;
            repl_cnt_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                head_reg         <= head_next;
                count_reg        <= count_next;
                status_valid_reg <= status_valid_next;
                status_entry_reg <= status_entry_next;
                drop_cnt_reg     <= drop_cnt_next;
                repl_cnt_reg     <= repl_cnt_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            code_reg        <= code_next;
            got_reg         <= got_next;
            from_status_reg <= from_status_next;
        end
        if (accept && ring_we) begin
            ring_reg[wr_idx] <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_limit_reg   <= dopq_pkg::ITEM_LIMIT_RESET;
            status_en_reg    <= 1'b0;
            status_topic_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                dopq_pkg::REG_ITEM_LIMIT:    item_limit_reg   <= pwdata[4:0];
                dopq_pkg::REG_STATUS_ENABLE: status_en_reg    <= pwdata[0];
                dopq_pkg::REG_STATUS_TOPIC:  status_topic_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            dopq_pkg::REG_ITEM_LIMIT:    prdata = dopq_pkg::PDATA_W'(item_limit_reg);
            dopq_pkg::REG_STATUS_ENABLE: prdata = dopq_pkg::PDATA_W'(status_en_reg);
            dopq_pkg::REG_STATUS_TOPIC:  prdata = dopq_pkg::PDATA_W'(status_topic_reg);
            default:                     prdata = '0;
        endcase
    end

    // The totals and the fill shown are those left after the request.
    assign m_valid           = m_valid_reg;
    assign m_result_code     = code_reg;
    assign m_out_topic_id    = got_reg.topic;
    assign m_out_payload     = got_reg.payload;
    assign m_out_qos         = got_reg.qos;
    assign m_out_retain      = got_reg.retain;
    assign m_out_from_status = from_status_reg;
    assign m_queued_count    = 5'(count_reg);
    assign m_dropped_total   = drop_cnt_reg;
    assign m_replaced_total  = repl_cnt_reg;

    a_enq_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_opcode == dopq_pkg::OP_ENQUEUE)
        |=> m_valid && (m_result_code == dopq_pkg::RC_ENQUEUED))
        else $error("enqueue did not produce an enqueued result");

    a_pop_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_opcode == dopq_pkg::OP_POP) && (count_reg != '0)
        |=> (count_reg == $past(count_reg) - dopq_pkg::CNT_W'(1))
            && !m_out_from_status)
        else $error("ring pop did not take one entry from the ring");

    a_empty_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_code == dopq_pkg::RC_EMPTY)
        |-> (m_queued_count == 5'd0) && !status_valid_reg)
        else $error("empty result while entries are held");

    a_drop_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (drop_cnt_reg >= $past(drop_cnt_reg))
                           && (repl_cnt_reg >= $past(repl_cnt_reg)))
        else $error("a total went backwards");

endmodule

`default_nettype wire

// ===== dv/dopq_result_checker.sv =====
`timescale 1ns / 1ps

module dopq_result_checker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    input  wire logic                         s_valid,
    input  wire logic                         s_ready,
    input  wire logic                         s_opcode,
    input  wire logic [15:0]                  s_topic_id,
    input  wire logic [15:0]                  s_payload_handle,
    input  wire logic [1:0]                   s_qos,
    input  wire logic                         s_retain,

    input  wire logic                         m_valid,
    input  wire logic                         m_ready,
    input  wire logic [1:0]                   m_result_code,
    input  wire logic [15:0]                  m_out_topic_id,
    input  wire logic [15:0]                  m_out_payload,
    input  wire logic [1:0]                   m_out_qos,
    input  wire logic                         m_out_retain,
    input  wire logic                         m_out_from_status,
    input  wire logic [4:0]                   m_queued_count,
    input  wire logic [15:0]                  m_dropped_total,
    input  wire logic [15:0]                  m_replaced_total,

    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dopq_pkg::PADDR_W-1:0] paddr,
    input  wire logic [dopq_pkg::PDATA_W-1:0] pwdata,
    input  wire logic [dopq_pkg::PDATA_W-1:0] prdata,
    input  wire logic                         pready,

    output int                                fail_count,
    output int                                pending
);

    typedef struct packed {
        logic [1:0]      code;
        dopq_pkg::item_t item;
        logic            from_status;
        logic [4:0]      queued;
        logic [15:0]     dropped;
        logic [15:0]     replaced;
    } queue_result_t;

    // Shadow of the queue contents and the configuration registers.
    dopq_pkg::item_t ring_copy [dopq_pkg::CAPACITY];
    int              head_pos;
    int              held;
    logic            slot_valid;
    dopq_pkg::item_t slot_item;
    logic [15:0]     dropped;
    logic [15:0]     replaced;
    logic [4:0]      cfg_item_limit;
    logic            cfg_status_en;
    logic [15:0]     cfg_status_topic;

    queue_result_t results_due [$];
    queue_result_t want;
    queue_result_t got;
    queue_result_t next_result;
    logic [31:0]   read_want;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic predict_queue_step(input logic op, input dopq_pkg::item_t req,
                                      output queue_result_t r);
        int lim;
        r = '0;
        lim = (cfg_item_limit == 5'd0 || int'(cfg_item_limit) > dopq_pkg::CAPACITY) ?
              dopq_pkg::CAPACITY : int'(cfg_item_limit);
        if (op == dopq_pkg::OP_ENQUEUE) begin
            r.code = dopq_pkg::RC_ENQUEUED;
            if (cfg_status_en && req.topic == cfg_status_topic) begin
                if (slot_valid && replaced != 16'hFFFF)
                    replaced = replaced + 16'd1;
                slot_item  = req;
                slot_valid = 1'b1;
            end else begin
                // A full ring (or one over a lowered limit) loses only its oldest entry.
                if (held >= lim && held > 0) begin
                    head_pos = (head_pos + 1) % dopq_pkg::CAPACITY;
                    held     = held - 1;
                    if (dropped != 16'hFFFF)
                        dropped = dropped + 16'd1;
                end
                ring_copy[(head_pos + held) % dopq_pkg::CAPACITY] = req;
                held = held + 1;
            end
        end else if (held > 0) begin
            r.code   = dopq_pkg::RC_POPPED;
            r.item   = ring_copy[head_pos];
            head_pos = (head_pos + 1) % dopq_pkg::CAPACITY;
            held     = held - 1;
        end else if (slot_valid) begin
            r.code        = dopq_pkg::RC_POPPED;
            r.item        = slot_item;
            r.from_status = 1'b1;
            slot_item     = '0;
            slot_valid    = 1'b0;
        end else begin
            r.code = dopq_pkg::RC_EMPTY;
        end
        r.queued   = 5'(held);
        r.dropped  = dropped;
        r.replaced = replaced;
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            head_pos         = 0;
            held             = 0;
            slot_valid       = 1'b0;
            slot_item        = '0;
            dropped          = '0;
            replaced         = '0;
            cfg_item_limit   = dopq_pkg::ITEM_LIMIT_RESET;
            cfg_status_en    = 1'b0;
            cfg_status_topic = '0;
            results_due.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[3:2])
                        dopq_pkg::REG_ITEM_LIMIT:    cfg_item_limit   = pwdata[4:0];
                        dopq_pkg::REG_STATUS_ENABLE: cfg_status_en    = pwdata[0];
                        dopq_pkg::REG_STATUS_TOPIC:  cfg_status_topic = pwdata[15:0];
                        default: ;
                    endcase
                end else begin
                    case (paddr[3:2])
                        dopq_pkg::REG_ITEM_LIMIT:    read_want = {27'd0, cfg_item_limit};
                        dopq_pkg::REG_STATUS_ENABLE: read_want = {31'd0, cfg_status_en};
                        dopq_pkg::REG_STATUS_TOPIC:  read_want = {16'd0, cfg_status_topic};
                        default:                     read_want = prdata;
                    endcase
                    check_field("register read", read_want, prdata);
                end
            end

            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result arrived with none expected, code %0d",
                             $time, m_result_code);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    got.code        = m_result_code;
                    got.item.topic  = m_out_topic_id;
                    got.item.payload = m_out_payload;
                    got.item.qos    = m_out_qos;
                    got.item.retain = m_out_retain;
                    got.from_status = m_out_from_status;
                    got.queued      = m_queued_count;
                    got.dropped     = m_dropped_total;
                    got.replaced    = m_replaced_total;
                    check_field("result_code", 32'(want.code), 32'(got.code));
                    check_field("out_topic_id", 32'(want.item.topic),
                                32'(got.item.topic));
                    check_field("out_payload", 32'(want.item.payload),
                                32'(got.item.payload));
                    check_field("out_qos", 32'(want.item.qos), 32'(got.item.qos));
                    check_field("out_retain", 32'(want.item.retain),
                                32'(got.item.retain));
                    check_field("out_from_status", 32'(want.from_status),
                                32'(got.from_status));
                    check_field("queued_count", 32'(want.queued), 32'(got.queued));
                    check_field("dropped_total", 32'(want.dropped), 32'(got.dropped));
                    check_field("replaced_total", 32'(want.replaced),
                                32'(got.replaced));
                end
            end

            if (s_valid && s_ready) begin
                predict_queue_step(s_opcode,
                                   '{topic: s_topic_id, payload: s_payload_handle,
                                     qos: s_qos, retain: s_retain},
                                   next_result);
                results_due.push_back(next_result);
            end
        end
        pending = results_due.size();
    end

endmodule

// ===== dv/drop_oldest_publish_queue_tb.sv =====
`timescale 1ns / 1ps

module drop_oldest_publish_queue_tb;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = dopq_pkg::OP_ENQUEUE;
    logic [15:0] s_topic_id = '0;
    logic [15:0] s_payload_handle = '0;
    logic [1:0]  s_qos = '0;
    logic        s_retain = 1'b0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_result_code;
    logic [15:0] m_out_topic_id;
    logic [15:0] m_out_payload;
    logic [1:0]  m_out_qos;
    logic        m_out_retain;
    logic        m_out_from_status;
    logic [4:0]  m_queued_count;
    logic [15:0] m_dropped_total;
    logic [15:0] m_replaced_total;

    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [dopq_pkg::PADDR_W-1:0]   paddr = '0;
    logic [dopq_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [dopq_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_request = 0;
    logic [15:0] status_topic_now = '0;

    always #5 aclk = ~aclk;

    drop_oldest_publish_queue u_top (.*);

    dopq_result_checker u_checker (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random back-pressure, plus a long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so back-to-back requests need no gap.
    task automatic send_request(input logic op, input logic [15:0] topic,
                                input logic [15:0] payload, input logic [1:0] qos,
                                input logic retain);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_opcode         <= op;
        s_topic_id       <= topic;
        s_payload_handle <= payload;
        s_qos            <= qos;
        s_retain         <= retain;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic enqueue(input logic [15:0] topic, input logic [15:0] payload,
                           input logic [1:0] qos, input logic retain);
        send_request(dopq_pkg::OP_ENQUEUE, topic, payload, qos, retain);
    endtask

    task automatic pop_request();
        send_request(dopq_pkg::OP_POP, 16'($urandom), 16'($urandom),
                     2'($urandom_range(3)), 1'($urandom_range(1)));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    // Leaves the bus idle after the access so that the next access starts
    // at a falling edge of its own.
    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [4:0] limit_val, input logic enable,
                              input logic [15:0] topic);
        wait_drained();
        apb_access(1'b1, dopq_pkg::REG_ITEM_LIMIT, {27'd0, limit_val});
        apb_access(1'b1, dopq_pkg::REG_STATUS_ENABLE, {31'd0, enable});
        apb_access(1'b1, dopq_pkg::REG_STATUS_TOPIC, {16'd0, topic});
        apb_access(1'b0, dopq_pkg::REG_ITEM_LIMIT, '0);
        apb_access(1'b0, dopq_pkg::REG_STATUS_ENABLE, '0);
        apb_access(1'b0, dopq_pkg::REG_STATUS_TOPIC, '0);
        status_topic_now = topic;
    endtask

    // Pop share drifts in bursts so the ring alternately fills up and drains.
    task automatic random_phase(input int n_items, input int hold_at);
        int          pop_pct;
        int          pick;
        logic [15:0] topic;
        pop_pct = 50;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0)
                pop_pct = $urandom_range(15, 85);
            if (i == hold_at)
                hold_request = 400;
            if ($urandom_range(99) < pop_pct) begin
                pop_request();
            end else begin
                pick = $urandom_range(9);
                if (pick < 3)
                    topic = status_topic_now;
                else if (pick < 5)
                    topic = status_topic_now ^ (16'd1 << $urandom_range(15));
                else
                    topic = 16'($urandom);
                enqueue(topic, 16'($urandom), 2'($urandom_range(3)),
                        1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset configuration: plain ring, no status topic.
        pop_request();
        enqueue(16'hFFFF, 16'hFFFF, 2'd3, 1'b1);
        enqueue(16'h0000, 16'h0000, 2'd0, 1'b0);
        pop_request();
        pop_request();
        pop_request();

        // Status slot replacement and drop on a full ring of three.
        set_config(5'd3, 1'b1, 16'hABCD);
        enqueue(16'hABCD, 16'h1111, 2'd1, 1'b0);
        enqueue(16'hABCD, 16'h2222, 2'd2, 1'b1);
        enqueue(16'hABCC, 16'h0001, 2'd0, 1'b1);
        enqueue(16'h2BCD, 16'h0002, 2'd3, 1'b0);
        enqueue(16'h0000, 16'h0003, 2'd1, 1'b1);
        enqueue(16'hFFFF, 16'h0004, 2'd2, 1'b0);
        repeat (5) pop_request();

        // Lowering the limit under the current fill drops one per enqueue.
        set_config(5'd16, 1'b1, 16'hABCD);
        for (int i = 0; i < 6; i++)
            enqueue(16'(i), 16'(16'h100 + i), 2'(i), 1'(i));
        set_config(5'd2, 1'b1, 16'hABCD);
        enqueue(16'h7777, 16'h8888, 2'd3, 1'b1);
        pop_request();
        pop_request();

        set_config(5'd16, 1'b1, 16'h0000);
        send_idle_pct = 19;
        recv_idle_pct = 87;
        random_phase(255, -1);
        set_config(5'd0, 1'b1, 16'hFFFF);
        random_phase(255, -1);

        set_config(5'd1, 1'b0, 16'($urandom));
        send_idle_pct = 87;
        recv_idle_pct = 19;
        random_phase(255, -1);
        set_config(5'd31, 1'b1, 16'($urandom));
        random_phase(255, -1);

        set_config(5'd3, 1'b1, 16'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(255, 60);
        set_config(5'd8, 1'b0, 16'h8000);
        random_phase(255, -1);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
